/* hdl/scbp_pkg.sv */
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants for the serial command button pulser.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int CODE_BITS_DEF  = 4;
  localparam int TIMER_BITS_DEF = 24;

  localparam int BIT_TICKS_W   = 16;
  localparam int PRESS_TICKS_W = 24;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [BIT_TICKS_W-1:0]   BIT_TICKS_RST   = 16'd100;
  localparam logic [PRESS_TICKS_W-1:0] PRESS_TICKS_RST = 24'd120000;
  localparam logic [PRESS_TICKS_W-1:0] HOLD_TICKS_RST  = 24'd120000;

  localparam int OUT_COUNT = 5;
  localparam int OUT_W     = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_TICKS   = 2'd0,
    REG_PRESS_TICKS = 2'd1,
    REG_HOLD_TICKS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [OUT_W-1:0] {
    OUT_ENC_UP   = 3'd0,
    OUT_ENC_DOWN = 3'd1,
    OUT_EXP      = 3'd2,
    OUT_OK       = 3'd3,
    OUT_SWITCH   = 3'd4,
    OUT_NONE     = 3'd7
  } out_sel_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_RECV  = 4'b0010,
    PH_TAIL  = 4'b0100,
    PH_PULSE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [OUT_COUNT-1:0] pins;
    logic                 busy;
  } res_t;

endpackage

/* hdl/serial_command_button_pulser.sv */
// ----------------------------------------------------------------------------
// serial_command_button_pulser
// Receives short serial command codes and drives a timed pulse on one of
// five button outputs.
// ----------------------------------------------------------------------------
// Channel  | Handshake                   | Payload
// sample   | sample_valid / sample_stall | line_level
// result   | result_valid / result_stall | enc_up_pin .. switch_button_pin, busy_res
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One sample per cycle unless stalled; each request yields one registered result.
// The state update is a single pass from the state registers to the result
// register; a two-entry output buffer (result plus skid) keeps the input open
// while one result waits. sample_stall is high only while the skid is full.
// Synchronous reset clears state, timer, config registers to defaults.
// ----------------------------------------------------------------------------
module serial_command_button_pulser
  import scbp_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic                   line_level,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   enc_up_pin,
  output logic                   enc_down_pin,
  output logic                   exp_button_pin,
  output logic                   ok_button_pin,
  output logic                   switch_button_pin,
  output logic                   busy_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LOAD_W  = 33;
  localparam int COUNT_W = $clog2(CODE_BITS + 1);
  localparam logic [LOAD_W-1:0] TIMER_MAX = (LOAD_W'(1) << TIMER_BITS) - LOAD_W'(1);

  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [LOAD_W-1:0] v);
    logic [LOAD_W-1:0] s;
    s = (v > TIMER_MAX) ? TIMER_MAX : v;
    if (s == '0) begin
      s = LOAD_W'(1);
    end
    return s[TIMER_BITS-1:0];
  endfunction

  logic [BIT_TICKS_W-1:0]   bit_ticks;
  logic [PRESS_TICKS_W-1:0] press_ticks;
  logic [PRESS_TICKS_W-1:0] hold_ticks;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] tick_timer, tick_timer_next, timer_dec;
  logic [COUNT_W-1:0]    bits_taken, bits_taken_next;
  logic [CODE_BITS-1:0]  code_shift, code_shift_next;
  out_sel_t              active_output, active_output_next;

  res_t res_new, head, skid;
  logic skid_valid;
  logic accept, take;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks   <= BIT_TICKS_RST;
      press_ticks <= PRESS_TICKS_RST;
      hold_ticks  <= HOLD_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_TICKS:   bit_ticks   <= cfg_data[BIT_TICKS_W-1:0];
        REG_PRESS_TICKS: press_ticks <= cfg_data;
        REG_HOLD_TICKS:  hold_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign sample_stall = skid_valid;
  assign accept       = sample_valid && !skid_valid;
  assign take         = result_valid && !result_stall;

  // next state
  assign timer_dec = tick_timer - TIMER_BITS'(1);

  always_comb begin
    phase_next         = phase;
    tick_timer_next    = tick_timer;
    bits_taken_next    = bits_taken;
    code_shift_next    = code_shift;
    active_output_next = active_output;
    case (phase)
      PH_IDLE: begin
        if (!line_level) begin
          phase_next      = PH_RECV;
          tick_timer_next = timer_load(LOAD_W'(bit_ticks) + LOAD_W'(bit_ticks >> 1));
          bits_taken_next = '0;
          code_shift_next = '0;
        end
      end
      PH_RECV: begin
        tick_timer_next = timer_dec;
        if (timer_dec == '0) begin
          code_shift_next = (code_shift >> 1)
                          | (CODE_BITS'(line_level) << (CODE_BITS - 1));
          bits_taken_next = bits_taken + COUNT_W'(1);
          tick_timer_next = timer_load(LOAD_W'(bit_ticks));
          if (bits_taken_next == COUNT_W'(CODE_BITS)) begin
            phase_next = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        tick_timer_next = timer_dec;
        if (timer_dec == '0) begin
          if (32'(code_shift) < OUT_COUNT) begin
            active_output_next = out_sel_t'(OUT_W'(code_shift));
            phase_next         = PH_PULSE;
            tick_timer_next    = (32'(code_shift) == 32'(OUT_ENC_DOWN))
                               ? timer_load(LOAD_W'(hold_ticks))
                               : timer_load(LOAD_W'(press_ticks));
          end else begin
            phase_next         = PH_IDLE;
            active_output_next = OUT_NONE;
          end
        end
      end
      PH_PULSE: begin
        tick_timer_next = timer_dec;
        if (timer_dec == '0) begin
          phase_next         = PH_IDLE;
          active_output_next = OUT_NONE;
        end
      end
      default: begin
        phase_next         = PH_IDLE;
        active_output_next = OUT_NONE;
      end
    endcase
  end

  always_comb begin
    res_new.pins = '0;
    if (phase_next == PH_PULSE) begin
      case (active_output_next)
        OUT_ENC_UP:   res_new.pins[0] = 1'b1;
        OUT_ENC_DOWN: res_new.pins[1] = 1'b1;
        OUT_EXP:      res_new.pins[2] = 1'b1;
        OUT_OK:       res_new.pins[3] = 1'b1;
        OUT_SWITCH:   res_new.pins[4] = 1'b1;
        default:      res_new.pins    = '0;
      endcase
    end
    res_new.busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_timer    <= '0;
      bits_taken    <= '0;
      code_shift    <= '0;
      active_output <= OUT_NONE;
    end else if (accept) begin
      phase         <= phase_next;
      tick_timer    <= tick_timer_next;
      bits_taken    <= bits_taken_next;
      code_shift    <= code_shift_next;
      active_output <= active_output_next;
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      if (result_valid) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      head <= skid;
    end else if (accept && (take || !result_valid)) begin
      head <= res_new;
    end
    if (accept && result_valid && !take) begin
      skid <= res_new;
    end
  end

  assign enc_up_pin        = head.pins[0];
  assign enc_down_pin      = head.pins[1];
  assign exp_button_pin    = head.pins[2];
  assign ok_button_pin     = head.pins[3];
  assign switch_button_pin = head.pins[4];
  assign busy_res          = head.busy;

endmodule

/* hdl/scbp_checker.sv */
// ----------------------------------------------------------------------------
// scbp_checker
// Port-level checks for the serial command button pulser.
// ----------------------------------------------------------------------------
module scbp_checker (
  input logic clk,
  input logic rst,
  input logic sample_stall,
  input logic result_valid,
  input logic result_stall,
  input logic enc_up_pin,
  input logic enc_down_pin,
  input logic exp_button_pin,
  input logic ok_button_pin,
  input logic switch_button_pin,
  input logic busy_res
);

  logic [4:0] pins;
  assign pins = {switch_button_pin, ok_button_pin, exp_button_pin,
                 enc_down_pin, enc_up_pin};

  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(pins))
    else $error("more than one button pin high");

  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && pins != 5'b0) |-> busy_res)
    else $error("pin high while not busy");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !sample_stall))
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(pins) && $stable(busy_res)))
    else $error("stalled result changed");

endmodule

bind serial_command_button_pulser scbp_checker u_scbp_checker (
  .clk               (clk),
  .rst               (rst),
  .sample_stall      (sample_stall),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .enc_up_pin        (enc_up_pin),
  .enc_down_pin      (enc_down_pin),
  .exp_button_pin    (exp_button_pin),
  .ok_button_pin     (ok_button_pin),
  .switch_button_pin (switch_button_pin),
  .busy_res          (busy_res)
);
